// ===== hw/rtl/adc_bank_word_parser_top_macros.svh =====
// assertion helpers, clocked on clock and quiet while reset is high
`ifndef ADC_BANK_WORD_PARSER_TOP_MACROS_SVH
`define ADC_BANK_WORD_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define ABWP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ABWP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/abwp_pkg.sv =====
package abwp_pkg;

   localparam int NUM_BOARDS_DEF        = 16;
   localparam int CHANNELS_PER_MEZZ_DEF = 2048;

   localparam int WORD_W   = 32;
   localparam int BOARD_W  = 4;
   localparam int CHAN_W   = 11;
   localparam int ADC_W    = 12;
   localparam int STATUS_W = 3;
   localparam int LEFT_W   = 12;
   localparam int TOTAL_W  = 17;

   typedef enum logic [STATUS_W-1:0] {
      ST_HEADER      = 3'd0,
      ST_WRITTEN     = 3'd1,
      ST_SKIPPED     = 3'd2,
      ST_BAD_BOARD   = 3'd3,
      ST_BAD_MEZZ    = 3'd4,
      ST_COUNT_BIG   = 3'd5,
      ST_CHANNEL_BIG = 3'd6,
      ST_DISCARDED   = 3'd7
   } status_type;

   typedef struct packed {
      logic [LEFT_W-1:0]  words_left;
      logic [BOARD_W-1:0] board;
      logic               mezzanine;
      logic [TOTAL_W-1:0] written;
      logic               error;
   } bank_state_type;

   typedef struct packed {
      logic               write_enable;
      logic               out_sector;
      logic [BOARD_W-1:0] board;
      logic               mezzanine;
      logic [CHAN_W-1:0]  channel;
      logic [ADC_W-1:0]   adc_value;
      status_type         status;
      logic               bank_done;
      logic               bank_error;
      logic [TOTAL_W-1:0] channel_total;
   } result_type;

endpackage

// ===== hw/rtl/abwp_channels.sv =====
interface abwp_req_if;
   import abwp_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              last_word;

   modport source (output valid, word, last_word, input ready);
   modport sink   (input valid, word, last_word, output ready);
endinterface

interface abwp_rsp_if;
   import abwp_pkg::*;
   logic                valid;
   logic                ready;
   logic                write_enable;
   logic                out_sector;
   logic [BOARD_W-1:0]  board;
   logic                mezzanine;
   logic [CHAN_W-1:0]   channel;
   logic [ADC_W-1:0]    adc_value;
   logic [STATUS_W-1:0] status;
   logic                bank_done;
   logic                bank_error;
   logic [TOTAL_W-1:0]  channel_total;

   modport source (output valid, write_enable, out_sector, board, mezzanine, channel,
                   adc_value, status, bank_done, bank_error, channel_total,
                   input ready);
   modport sink   (input valid, write_enable, out_sector, board, mezzanine, channel,
                   adc_value, status, bank_done, bank_error, channel_total,
                   output ready);
endinterface

// ===== hw/rtl/abwp_decode.sv =====
module abwp_decode
   import abwp_pkg::*;
#(
   parameter int NUM_BOARDS        = NUM_BOARDS_DEF,
   parameter int CHANNELS_PER_MEZZ = CHANNELS_PER_MEZZ_DEF
) (
   input  bank_state_type    state,
   input  logic [WORD_W-1:0] word,
   input  logic              last_word,
   input  logic              sector,
   output bank_state_type    state_next,
   output result_type        result
);

   localparam logic [8:0]  BOARD_LIMIT = 9'(NUM_BOARDS);
   localparam logic [15:0] COUNT_LIMIT = 16'(CHANNELS_PER_MEZZ);
   localparam logic [11:0] CHAN_LIMIT  = 12'(CHANNELS_PER_MEZZ);

   logic [7:0]        hdr_board;
   logic [7:0]        hdr_mezz;
   logic [15:0]       hdr_count;
   logic              flagged;
   logic [CHAN_W-1:0] data_chan;
   logic [ADC_W-1:0]  data_value;
   bank_state_type    upd;

   assign hdr_board  = word[31:24];
   assign hdr_mezz   = word[23:16];
   assign hdr_count  = word[15:0];
   assign flagged    = word[30];
   assign data_chan  = word[22:12];
   assign data_value = word[11:0];

   always_comb begin
      upd                  = state;
      result               = '0;
      result.out_sector    = sector;
      result.board         = state.board;
      result.mezzanine     = state.mezzanine;
      result.bank_done     = last_word;

      if (state.error) begin
         result.status = ST_DISCARDED;
      end else if (state.words_left == '0) begin
         // header word
         result.board     = hdr_board[BOARD_W-1:0];
         result.mezzanine = hdr_mezz[0];
         if ({1'b0, hdr_board} >= BOARD_LIMIT) begin
            result.status = ST_BAD_BOARD;
            upd.error     = 1'b1;
         end else if (hdr_mezz > 8'd1) begin
            result.status = ST_BAD_MEZZ;
            upd.error     = 1'b1;
         end else if (hdr_count > COUNT_LIMIT) begin
            result.status = ST_COUNT_BIG;
            upd.error     = 1'b1;
         end else begin
            result.status  = ST_HEADER;
            upd.board      = hdr_board[BOARD_W-1:0];
            upd.mezzanine  = hdr_mezz[0];
            upd.words_left = hdr_count[LEFT_W-1:0];
         end
      end else begin
         // data word
         upd.words_left = state.words_left - LEFT_W'(1);
         if (flagged) begin
            result.channel   = data_chan;
            result.adc_value = data_value;
            if ({1'b0, data_chan} >= CHAN_LIMIT) begin
               result.status = ST_CHANNEL_BIG;
               upd.error     = 1'b1;
            end else begin
               result.status       = ST_WRITTEN;
               result.write_enable = 1'b1;
               if (state.written != '1) begin
                  upd.written = state.written + TOTAL_W'(1);
               end
            end
         end else begin
            result.status = ST_SKIPPED;
         end
      end

      if (last_word) begin
         result.bank_error    = upd.error;
         result.channel_total = upd.written;
         state_next           = '0;
      end else begin
         state_next = upd;
      end
   end

endmodule

// ===== hw/rtl/adc_bank_word_parser_top.sv =====
// latency: a word accepted at one edge has its result on rsp_chan from the next cycle on
// throughput: one word per cycle while rsp_chan takes results; the bank state and the result register
//   both update at the accept edge, and the result register frees itself when rsp_chan takes it
// reset: synchronous, active high; clears the bank state, the sector and the result
//   valid; the first word after reset is taken as a header
module adc_bank_word_parser_top
   import abwp_pkg::*;
#(
   parameter int NUM_BOARDS        = NUM_BOARDS_DEF,
   parameter int CHANNELS_PER_MEZZ = CHANNELS_PER_MEZZ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   abwp_req_if.sink    req_chan,
   abwp_rsp_if.source  rsp_chan
);

   // sector register, copied into every result
   logic sector_ff;

   // bank state: remaining data words, header fields, write count, sticky error
   bank_state_type state_ff;
   bank_state_type state_in;

   // result register, one word deep
   logic       rsp_valid_ff;
   result_type result_ff;
   result_type result_in;

   logic req_accept;

   // a new word enters whenever the result register is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // all per-word work is one combinational pass over the current state
   abwp_decode #(
      .NUM_BOARDS        (NUM_BOARDS),
      .CHANNELS_PER_MEZZ (CHANNELS_PER_MEZZ)
   ) u_decode (
      .state      (state_ff),
      .word       (req_chan.word),
      .last_word  (req_chan.last_word),
      .sector     (sector_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff <= 1'b0;
      end else if (csr_write_enable) begin
         sector_ff <= csr_write_data;
      end
   end

   // state advances only on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset, it is only looked at with valid
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.write_enable  = result_ff.write_enable;
   assign rsp_chan.out_sector    = result_ff.out_sector;
   assign rsp_chan.board         = result_ff.board;
   assign rsp_chan.mezzanine     = result_ff.mezzanine;
   assign rsp_chan.channel       = result_ff.channel;
   assign rsp_chan.adc_value     = result_ff.adc_value;
   assign rsp_chan.status        = result_ff.status;
   assign rsp_chan.bank_done     = result_ff.bank_done;
   assign rsp_chan.bank_error    = result_ff.bank_error;
   assign rsp_chan.channel_total = result_ff.channel_total;

`include "adc_bank_word_parser_top_macros.svh"

   // the last word of a bank leaves a clean state behind
   `ABWP_ASSERT_NEXT(a_last_clears, req_accept && req_chan.last_word, state_ff == '0, "bank state not cleared after last word")

   // an error stays until the bank ends
   `ABWP_ASSERT_NEXT(a_error_sticky, req_accept && state_ff.error && !req_chan.last_word, state_ff.error, "sticky error lost inside a bank")

   // once in error, every word comes back discarded
   `ABWP_ASSERT_NEXT(a_discard, req_accept && state_ff.error, rsp_valid_ff && result_ff.status == ST_DISCARDED, "word after an error not discarded")

   // totals are only reported on the last word
   `ABWP_ASSERT_NOW(a_total_only_done, rsp_valid_ff && !result_ff.bank_done, result_ff.channel_total == '0 && !result_ff.bank_error, "bank totals outside the last word")

endmodule
